// ===== hdl/sgr_pkg.sv =====
// Shared types, constants and the 5x7 font table of the scaled glyph rasterizer.
`default_nettype none

package sgr_pkg;

    // Screen size in pixels.
    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 240;

    // Font layout and printable code range.
    localparam int GLYPH_COLS = 5;
    localparam int GLYPH_ROWS = 8;
    localparam int FIRST_CODE = 32;
    localparam int LAST_CODE  = 126;
    localparam int NUM_GLYPHS = LAST_CODE - FIRST_CODE + 1;

    // Field widths.
    localparam int COORD_W = 16;
    localparam int CODE_W  = 8;
    localparam int COLOR_W = 16;
    localparam int SCALE_W = 4;
    localparam int WX_W    = 9;
    localparam int WY_W    = 8;
    localparam int GLYPH_W = GLYPH_COLS * 8;
    localparam int GIDX_W  = $clog2(NUM_GLYPHS);
    localparam int COL_W   = $clog2(GLYPH_COLS);
    localparam int ROW_W   = $clog2(GLYPH_ROWS);
    localparam int CLIP_W  = COORD_W + 2;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } sgr_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic push;
        logic flush;
    } sgr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic kept;
        logic last_pos;
        logic pend_valid;
        logic out_free;
    } sgr_stat_t;

    // One glyph per entry; column 0 in the top byte, bit 0 of a byte is row 0.
    localparam logic [GLYPH_W-1:0] GLYPH_ROM [0:NUM_GLYPHS-1] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
        40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
        40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
        40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
        40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
        40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
        40'h00007F0000, 40'h0041360800, 40'h08082A1C08
    };

    // Map a character byte to its glyph index; unprintable codes draw as space.
    function automatic logic [GIDX_W-1:0] glyph_index(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] offs;
        offs = code - CODE_W'(FIRST_CODE);
        if (code < CODE_W'(FIRST_CODE) || code > CODE_W'(LAST_CODE))
            return '0;
        return offs[GIDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/scaled_glyph_rasterizer.sv =====
// Top level of the scaled glyph rasterizer: controller plus datapath.
// The first window of a character moves from the pending register to the output
// when the next kept cell or the flush displaces it; the last window leaves after
// the scan of all 40 cells, one font cell per cycle unless a kept cell waits for
// the output slot, after the load; the next character is taken after the flush.
// Reset: rst_n clears the controller, scan position and valid flags at once.
`default_nettype none

module scaled_glyph_rasterizer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [sgr_pkg::COORD_W-1:0]   pos_x,
    input  wire logic [sgr_pkg::COORD_W-1:0]   pos_y,
    input  wire logic [sgr_pkg::CODE_W-1:0]    char_code,
    input  wire logic [sgr_pkg::COLOR_W-1:0]   fg_color,
    input  wire logic [sgr_pkg::COLOR_W-1:0]   bg_color,
    input  wire logic [sgr_pkg::SCALE_W-1:0]   scale,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [sgr_pkg::WX_W-1:0]           win_x0,
    output logic [sgr_pkg::WY_W-1:0]           win_y0,
    output logic [sgr_pkg::WX_W-1:0]           win_x1,
    output logic [sgr_pkg::WY_W-1:0]           win_y1,
    output logic [sgr_pkg::COLOR_W-1:0]        fill_color,
    output logic                               last_cell
);
    import sgr_pkg::*;

    sgr_cmd_t  cmd;
    sgr_stat_t stat;

    // Scan sequencer.
    sgr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Cell datapath and output register.
    sgr_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .char_code  (char_code),
        .fg_color   (fg_color),
        .bg_color   (bg_color),
        .scale      (scale),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .win_x0     (win_x0),
        .win_y0     (win_y0),
        .win_x1     (win_x1),
        .win_y1     (win_y1),
        .fill_color (fill_color),
        .last_cell  (last_cell)
    );

endmodule

`default_nettype wire

// ===== hdl/sgr_ctrl.sv =====
// Controller state machine: sequences the cell scan and the pending-window flush.
`default_nettype none

module sgr_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire sgr_pkg::sgr_stat_t stat,
    output sgr_pkg::sgr_cmd_t      cmd
);
    import sgr_pkg::*;

    sgr_state_t state_reg, state_next;
    logic can_step;

    // A kept cell may only displace the pending window when the output slot frees.
    assign can_step = !(stat.kept && stat.pend_valid) || stat.out_free;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (can_step && stat.last_pos)
                    state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                if (!stat.pend_valid || stat.out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Output logic.
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_SCAN:
            begin
                cmd.step = can_step;
                cmd.push = can_step && stat.kept && stat.pend_valid;
            end
            ST_FLUSH:
            begin
                cmd.flush = stat.pend_valid && stat.out_free;
            end
            default:
                in_stall = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/sgr_dp.sv =====
// Datapath: cell origin accumulators, clipping, pending window and output register.
`default_nettype none

module sgr_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire sgr_pkg::sgr_cmd_t             cmd,
    output sgr_pkg::sgr_stat_t                 stat,
    input  wire logic [sgr_pkg::COORD_W-1:0]   pos_x,
    input  wire logic [sgr_pkg::COORD_W-1:0]   pos_y,
    input  wire logic [sgr_pkg::CODE_W-1:0]    char_code,
    input  wire logic [sgr_pkg::COLOR_W-1:0]   fg_color,
    input  wire logic [sgr_pkg::COLOR_W-1:0]   bg_color,
    input  wire logic [sgr_pkg::SCALE_W-1:0]   scale,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [sgr_pkg::WX_W-1:0]           win_x0,
    output logic [sgr_pkg::WY_W-1:0]           win_y0,
    output logic [sgr_pkg::WX_W-1:0]           win_x1,
    output logic [sgr_pkg::WY_W-1:0]           win_y1,
    output logic [sgr_pkg::COLOR_W-1:0]        fill_color,
    output logic                               last_cell
);
    import sgr_pkg::*;

    localparam logic signed [CLIP_W-1:0] SW_S = CLIP_W'(SCREEN_WIDTH);
    localparam logic signed [CLIP_W-1:0] SH_S = CLIP_W'(SCREEN_HEIGHT);

    // Per-character registers.
    logic [GLYPH_W-1:0] glyph_reg;
    logic [COORD_W-1:0] cx_reg, cy_reg, py_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [COLOR_W-1:0] fg_reg, bg_reg;
    logic               bg_on_reg;
    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   row_reg;

    // Pending window and output register.
    logic               pend_valid_reg;
    logic [WX_W-1:0]    pend_x0_reg, pend_x1_reg;
    logic [WY_W-1:0]    pend_y0_reg, pend_y1_reg;
    logic [COLOR_W-1:0] pend_color_reg;
    logic               out_valid_reg;
    logic [WX_W-1:0]    out_x0_reg, out_x1_reg;
    logic [WY_W-1:0]    out_y0_reg, out_y1_reg;
    logic [COLOR_W-1:0] out_color_reg;
    logic               out_last_reg;

    // Cell evaluation signals.
    logic [7:0]               col_bits;
    logic                     dot;
    logic                     draw;
    logic [COLOR_W-1:0]       cell_color;
    logic signed [CLIP_W-1:0] xs, xe, x0c, x1c, x1m;
    logic signed [CLIP_W-1:0] ys, ye, y0c, y1c, y1m;
    logic                     kept;
    logic                     row_end;

    // Font dot of the current cell and its color.
    assign col_bits   = glyph_reg[GLYPH_W-1 -: 8];
    assign dot        = col_bits[row_reg];
    assign draw       = dot || bg_on_reg;
    assign cell_color = dot ? fg_reg : bg_reg;

    // Clip the cell on both axes: keep it when it is drawn and the clipped span is not empty.
    always_comb
    begin
        xs  = {{(CLIP_W-COORD_W){cx_reg[COORD_W-1]}}, cx_reg};
        xe  = xs + CLIP_W'(scale_reg);
        x0c = xs[CLIP_W-1] ? '0 : xs;
        x1c = (xe > SW_S) ? SW_S : xe;
        x1m = x1c - CLIP_W'(1);
        ys  = {{(CLIP_W-COORD_W){cy_reg[COORD_W-1]}}, cy_reg};
        ye  = ys + CLIP_W'(scale_reg);
        y0c = ys[CLIP_W-1] ? '0 : ys;
        y1c = (ye > SH_S) ? SH_S : ye;
        y1m = y1c - CLIP_W'(1);
        kept = draw && (x1c > x0c) && (y1c > y0c);
    end

    assign row_end = (row_reg == ROW_W'(GLYPH_ROWS - 1));

    // Status to the controller.
    assign stat.kept       = kept;
    assign stat.last_pos   = row_end && (col_reg == COL_W'(GLYPH_COLS - 1));
    assign stat.pend_valid = pend_valid_reg;
    assign stat.out_free   = !out_valid_reg || !out_stall;

    // Control registers: scan position and valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (cmd.step)
            begin
                if (row_end)
                begin
                    row_reg <= '0;
                    col_reg <= col_reg + COL_W'(1);
                end
                else
                begin
                    row_reg <= row_reg + ROW_W'(1);
                end
            end

            if (cmd.flush)
                pend_valid_reg <= 1'b0;
            else if (cmd.step && kept)
                pend_valid_reg <= 1'b1;

            if (cmd.push || cmd.flush)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers: glyph, origins, colors and windows.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            glyph_reg <= GLYPH_ROM[glyph_index(char_code)];
            cx_reg    <= pos_x;
            cy_reg    <= pos_y;
            py_reg    <= pos_y;
            scale_reg <= scale;
            fg_reg    <= fg_color;
            bg_reg    <= bg_color;
            bg_on_reg <= (bg_color != '0) && (bg_color != fg_color);
        end
        else if (cmd.step)
        begin
            if (row_end)
            begin
                glyph_reg <= glyph_reg << 8;
                cx_reg    <= cx_reg + COORD_W'(scale_reg);
                cy_reg    <= py_reg;
            end
            else
            begin
                cy_reg <= cy_reg + COORD_W'(scale_reg);
            end
        end

        // A kept cell becomes the pending window.
        if (cmd.step && kept)
        begin
            pend_x0_reg    <= x0c[WX_W-1:0];
            pend_x1_reg    <= x1m[WX_W-1:0];
            pend_y0_reg    <= y0c[WY_W-1:0];
            pend_y1_reg    <= y1m[WY_W-1:0];
            pend_color_reg <= cell_color;
        end

        // The pending window moves to the output; a flush marks it last.
        if (cmd.push || cmd.flush)
        begin
            out_x0_reg    <= pend_x0_reg;
            out_x1_reg    <= pend_x1_reg;
            out_y0_reg    <= pend_y0_reg;
            out_y1_reg    <= pend_y1_reg;
            out_color_reg <= pend_color_reg;
            out_last_reg  <= cmd.flush;
        end
    end

    assign out_valid  = out_valid_reg;
    assign win_x0     = out_x0_reg;
    assign win_y0     = out_y0_reg;
    assign win_x1     = out_x1_reg;
    assign win_y1     = out_y1_reg;
    assign fill_color = out_color_reg;
    assign last_cell  = out_last_reg;

endmodule

`default_nettype wire

// ===== hdl/sgr_checker.sv =====
// Port-level checker for the scaled glyph rasterizer and its bind statement.
`default_nettype none

module sgr_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_stall,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic [sgr_pkg::WX_W-1:0]      win_x0,
    input wire logic [sgr_pkg::WY_W-1:0]      win_y0,
    input wire logic [sgr_pkg::WX_W-1:0]      win_x1,
    input wire logic [sgr_pkg::WY_W-1:0]      win_y1,
    input wire logic [sgr_pkg::COLOR_W-1:0]   fill_color,
    input wire logic                          last_cell
);
    import sgr_pkg::*;

    // A stalled window holds until it is transferred.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(win_x0) && $stable(win_y0)
            && $stable(win_x1) && $stable(win_y1) && $stable(fill_color)
            && $stable(last_cell))
        else $error("stalled window changed");

    // Every window is ordered and lies on the screen.
    a_win_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> win_x0 <= win_x1 && win_y0 <= win_y1
            && win_x1 < WX_W'(SCREEN_WIDTH) && win_y1 < WY_W'(SCREEN_HEIGHT))
        else $error("window off screen or inverted");

    // After a character transfer the block is busy scanning.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while scanning");

    // A window is no larger than the largest cell.
    a_win_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (win_x1 - win_x0) < WX_W'(15) && (win_y1 - win_y0) < WY_W'(15))
        else $error("window larger than a cell");

endmodule

bind scaled_glyph_rasterizer sgr_checker u_sgr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .win_x0     (win_x0),
    .win_y0     (win_y0),
    .win_x1     (win_x1),
    .win_y1     (win_y1),
    .fill_color (fill_color),
    .last_cell  (last_cell)
);

`default_nettype wire
